/* rtl/cdm_pkg.sv */
// Package for the concentric disk map: formats, constants, control struct,
// and the CORDIC arctangent table. No dependencies.
package cdm_pkg;

  localparam int CDM_FRAC_BITS    = 16;
  localparam int CDM_CORDIC_STEPS = 18;

  // Internal angle and trig format: 30 fraction bits.
  localparam int IFRAC = 30;
  // Quotient bits of the ratio: t is at most 1.0, so one integer bit.
  localparam int QBITS = IFRAC + 1;
  // Width of CORDIC x, y and z words.
  localparam int CW    = 33;

  localparam logic [29:0] PI_QUARTER_Q30 = 30'd843314857;
  localparam logic [29:0] GAIN_Q30       = 30'd652032874;

  typedef struct packed {
    logic vld;    // item present in this stage
    logic first;  // |a| > |b| branch
    logic zero;   // center of the square
    logic neg;    // ratio is negative
  } ctl_t;

  // Arctangent of 2^-i at 30 fraction bits.
  function automatic logic [29:0] atan_entry(input int i);
    logic [29:0] val;
    case (i)
      0:       val = 30'd843314856;
      1:       val = 30'd497837829;
      2:       val = 30'd263043836;
      3:       val = 30'd133525158;
      4:       val = 30'd67021686;
      5:       val = 30'd33543515;
      6:       val = 30'd16775850;
      7:       val = 30'd8388437;
      8:       val = 30'd4194282;
      9:       val = 30'd2097149;
      default: val = (i >= IFRAC) ? 30'd0 : (30'd1 << (IFRAC - i));
    endcase
    return val;
  endfunction

endpackage

/* rtl/cdm_div.sv */
// Pipelined restoring divider: one quotient bit per stage, QBITS stages.
// Depends on cdm_pkg.
module cdm_div #(
  parameter int FRAC_BITS = cdm_pkg::CDM_FRAC_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cdm_pkg::ctl_t             ctl_i,
  input  logic [FRAC_BITS+1:0]      r_i,
  input  logic [FRAC_BITS:0]        mn_i,
  input  logic [FRAC_BITS:0]        md_i,
  output cdm_pkg::ctl_t             ctl_o,
  output logic [FRAC_BITS+1:0]      r_o,
  output logic [cdm_pkg::QBITS-1:0] quo_o
);
  import cdm_pkg::*;

  localparam int MW  = FRAC_BITS + 1;
  localparam int RMW = FRAC_BITS + 2;

  ctl_t             ctl_q [0:QBITS-1];
  logic [RMW-1:0]   rem_q [0:QBITS-1];
  logic [MW-1:0]    md_q  [0:QBITS-1];
  logic [RMW-1:0]   r_q   [0:QBITS-1];
  logic [QBITS-1:0] quo_q [0:QBITS-1];

  for (genvar k = 0; k < QBITS; k++) begin : g_stage
    ctl_t             ctl_in;
    logic [RMW-1:0]   rem_in;
    logic [MW-1:0]    md_in;
    logic [RMW-1:0]   r_in;
    logic [QBITS-1:0] quo_in;
    logic             ge;
    logic [RMW-1:0]   rem_d;

    if (k == 0) begin : g_head
      assign ctl_in = ctl_i;
      assign rem_in = {1'b0, mn_i};
      assign md_in  = md_i;
      assign r_in   = r_i;
      assign quo_in = '0;
    end else begin : g_body
      assign ctl_in = ctl_q[k-1];
      assign rem_in = rem_q[k-1];
      assign md_in  = md_q[k-1];
      assign r_in   = r_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    always_comb begin
      ge    = rem_in >= {1'b0, md_in};
      rem_d = ge ? rem_in - {1'b0, md_in} : rem_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else begin
        ctl_q[k] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= {rem_d[RMW-2:0], 1'b0};
      md_q[k]  <= md_in;
      r_q[k]   <= r_in;
      quo_q[k] <= {quo_in[QBITS-2:0], ge};
    end
  end

  assign ctl_o = ctl_q[QBITS-1];
  assign r_o   = r_q[QBITS-1];
  assign quo_o = quo_q[QBITS-1];

endmodule

/* rtl/cdm_cordic.sv */
// Pipelined rotation-mode CORDIC, one micro-rotation per stage.
// Depends on cdm_pkg.
module cdm_cordic #(
  parameter int FRAC_BITS    = cdm_pkg::CDM_FRAC_BITS,
  parameter int CORDIC_STEPS = cdm_pkg::CDM_CORDIC_STEPS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cdm_pkg::ctl_t                 ctl_i,
  input  logic [FRAC_BITS+1:0]          r_i,
  input  logic signed [cdm_pkg::CW-1:0] ang_i,
  output cdm_pkg::ctl_t                 ctl_o,
  output logic [FRAC_BITS+1:0]          r_o,
  output logic signed [cdm_pkg::CW-1:0] cos_o,
  output logic signed [cdm_pkg::CW-1:0] sin_o
);
  import cdm_pkg::*;

  ctl_t                 ctl_q [0:CORDIC_STEPS-1];
  logic [FRAC_BITS+1:0] r_q   [0:CORDIC_STEPS-1];
  logic signed [CW-1:0] x_q   [0:CORDIC_STEPS-1];
  logic signed [CW-1:0] y_q   [0:CORDIC_STEPS-1];
  logic signed [CW-1:0] z_q   [0:CORDIC_STEPS-1];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    ctl_t                 ctl_in;
    logic [FRAC_BITS+1:0] r_in;
    logic signed [CW-1:0] x_in, y_in, z_in, dx, dy, at;

    if (i == 0) begin : g_head
      assign ctl_in = ctl_i;
      assign r_in   = r_i;
      assign x_in   = CW'(signed'({1'b0, GAIN_Q30}));
      assign y_in   = '0;
      assign z_in   = ang_i;
    end else begin : g_body
      assign ctl_in = ctl_q[i-1];
      assign r_in   = r_q[i-1];
      assign x_in   = x_q[i-1];
      assign y_in   = y_q[i-1];
      assign z_in   = z_q[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;
    assign at = signed'({{(CW-30){1'b0}}, atan_entry(i)});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[i] <= '0;
      end else begin
        ctl_q[i] <= ctl_in;
      end
    end

    // Rotate toward zero residual angle.
    always_ff @(posedge clk_i) begin
      r_q[i] <= r_in;
      if (!z_in[CW-1]) begin
        x_q[i] <= x_in - dx;
        y_q[i] <= y_in + dy;
        z_q[i] <= z_in - at;
      end else begin
        x_q[i] <= x_in + dx;
        y_q[i] <= y_in - dy;
        z_q[i] <= z_in + at;
      end
    end
  end

  assign ctl_o = ctl_q[CORDIC_STEPS-1];
  assign r_o   = r_q[CORDIC_STEPS-1];
  assign cos_o = x_q[CORDIC_STEPS-1];
  assign sin_o = y_q[CORDIC_STEPS-1];

endmodule

/* rtl/concentric_disk_map_top.sv */
// Top level of the concentric square-to-disk map: front end, angle scaling,
// final scaling and rounding. Depends on cdm_pkg, cdm_div and cdm_cordic.
//
//  channel  | signals                  | handshake
//  ---------+--------------------------+------------------------------------
//  sample   | u_i, v_i                 | transfer when start_i && !busy_o
//  point    | disk_x_o, disk_y_o       | transfer when done_o (one cycle)
//
// One sample is taken every cycle; busy_o is never raised. The pipeline has
// one input register, a 31-stage divider for the ratio, two stages for the
// pi/4 scaling, one stage per CORDIC rotation and two stages for the radius
// product and rounding.
// Reset clears only the control words (valid and branch flags) travelling with the data.
// The receiver cannot stall, so the pipeline advances on every clock.
module concentric_disk_map_top #(
  parameter int FRAC_BITS    = cdm_pkg::CDM_FRAC_BITS,
  parameter int CORDIC_STEPS = cdm_pkg::CDM_CORDIC_STEPS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [FRAC_BITS-1:0]        u_i,
  input  logic [FRAC_BITS-1:0]        v_i,
  output logic                        done_o,
  output logic signed [FRAC_BITS+1:0] disk_x_o,
  output logic signed [FRAC_BITS+1:0] disk_y_o
);
  import cdm_pkg::*;

  localparam int AW  = FRAC_BITS + 2;     // a, b and r width
  localparam int MW  = FRAC_BITS + 1;     // magnitude width
  localparam int PW  = AW + CW;           // radius times trig product
  localparam int LAT = 36 + CORDIC_STEPS;
  localparam int TLW = 16;                // low slice of the ratio
  localparam int THW = QBITS - TLW;       // high slice of the ratio

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Front end: center the point and pick the branch.
  logic signed [AW-1:0] a, b, num, den;
  logic [MW-1:0]        ma, mb;
  ctl_t                 ctl_d, ctl_q;
  logic [AW-1:0]        r_q;
  logic [MW-1:0]        mn_q, md_q;
  logic [MW-1:0]        mn_d, md_d;

  always_comb begin
    a     = signed'({2'b00, u_i} << 1) - signed'(AW'(1) << FRAC_BITS);
    b     = signed'({2'b00, v_i} << 1) - signed'(AW'(1) << FRAC_BITS);
    ma    = a[AW-1] ? MW'(-a) : MW'(a);
    mb    = b[AW-1] ? MW'(-b) : MW'(b);
    ctl_d.vld   = accept;
    ctl_d.first = ma > mb;
    ctl_d.zero  = (a == '0) && (b == '0);
    num   = ctl_d.first ? b : a;
    den   = ctl_d.first ? a : b;
    ctl_d.neg   = num[AW-1] ^ den[AW-1];
    mn_d  = ctl_d.first ? mb : ma;
    md_d  = ctl_d.first ? ma : mb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q  <= den;
    mn_q <= mn_d;
    md_q <= md_d;
  end

  // Ratio of smaller to larger magnitude.
  ctl_t             div_ctl;
  logic [AW-1:0]    div_r;
  logic [QBITS-1:0] quo;

  cdm_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_q),
    .r_i    (r_q),
    .mn_i   (mn_q),
    .md_i   (md_q),
    .ctl_o  (div_ctl),
    .r_o    (div_r),
    .quo_o  (quo)
  );

  // Angle = t * pi/4, split into two partial products.
  ctl_t                 p1_ctl_q, p2_ctl_q;
  logic [AW-1:0]        p1_r_q, p2_r_q;
  logic [TLW+29:0]      pl_q;
  logic [THW+29:0]      ph_q;
  logic [61:0]          ang_sum;
  logic [29:0]          ang_mag;
  logic signed [CW-1:0] ang_q;

  always_comb begin
    ang_sum = (62'(ph_q) << TLW) + 62'(pl_q) + (62'd1 << (IFRAC - 1));
    ang_mag = ang_sum[IFRAC+29:IFRAC];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_ctl_q <= '0;
      p2_ctl_q <= '0;
    end else begin
      p1_ctl_q <= div_ctl;
      p2_ctl_q <= p1_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_r_q <= div_r;
    pl_q   <= quo[TLW-1:0] * PI_QUARTER_Q30;
    ph_q   <= quo[QBITS-1:TLW] * PI_QUARTER_Q30;
    p2_r_q <= p1_r_q;
    ang_q  <= p1_ctl_q.neg ? -CW'(signed'({3'b000, ang_mag}))
                           :  CW'(signed'({3'b000, ang_mag}));
  end

  // Sine and cosine.
  ctl_t                 cor_ctl;
  logic [AW-1:0]        cor_r;
  logic signed [CW-1:0] cos_v, sin_v;

  cdm_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (p2_ctl_q),
    .r_i    (p2_r_q),
    .ang_i  (ang_q),
    .ctl_o  (cor_ctl),
    .r_o    (cor_r),
    .cos_o  (cos_v),
    .sin_o  (sin_v)
  );

  // Scale by the radius; swap sine and cosine on the second branch.
  ctl_t                 f1_ctl_q, f2_ctl_q;
  logic signed [PW-1:0] px_q, py_q;
  logic signed [CW-1:0] tx, ty;
  logic signed [PW-1:0] rx, ry;
  logic signed [AW-1:0] ox_d, oy_d;
  logic signed [AW-1:0] ox_q, oy_q;

  assign tx = cor_ctl.first ? cos_v : sin_v;
  assign ty = cor_ctl.first ? sin_v : cos_v;

  // Round half up at IFRAC bits, then clamp to the closed unit range.
  function automatic logic signed [AW-1:0] fin(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    logic signed [PW-1:0] lim;
    logic signed [AW-1:0] res;
    s   = (p + (PW'(1) << (IFRAC - 1))) >>> IFRAC;
    lim = PW'(1) << FRAC_BITS;
    if (s > lim) begin
      res = AW'(lim);
    end else if (s < -lim) begin
      res = AW'(-lim);
    end else begin
      res = AW'(s);
    end
    return res;
  endfunction

  always_comb begin
    rx   = px_q;
    ry   = py_q;
    ox_d = f1_ctl_q.zero ? '0 : fin(rx);
    oy_d = f1_ctl_q.zero ? '0 : fin(ry);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_ctl_q <= '0;
      f2_ctl_q <= '0;
    end else begin
      f1_ctl_q <= cor_ctl;
      f2_ctl_q <= f1_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= PW'(signed'(cor_r)) * PW'(tx);
    py_q <= PW'(signed'(cor_r)) * PW'(ty);
    ox_q <= ox_d;
    oy_q <= oy_d;
  end

  assign done_o   = f2_ctl_q.vld;
  assign disk_x_o = ox_q;
  assign disk_y_o = oy_q;

  // Every accepted sample leaves the pipeline as a done_o strobe.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(accept, LAT))
    else $error("result strobe out of step with accepted samples");

  a_ratio : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_ctl.vld && !div_ctl.zero) |-> (quo <= (QBITS'(1) << IFRAC)))
    else $error("ratio above one");

  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (disk_x_o <= signed'(AW'(1) << FRAC_BITS))
            && (disk_x_o >= -signed'(AW'(1) << FRAC_BITS))
            && (disk_y_o <= signed'(AW'(1) << FRAC_BITS))
            && (disk_y_o >= -signed'(AW'(1) << FRAC_BITS)))
    else $error("disk point outside the clamp range");

endmodule

/* dv/cdm_checker.sv */
// Checker for the concentric disk map: predicts each disk point from the
// accepted samples and compares it with the point transfers. Uses cdm_pkg.
module cdm_checker (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  input  logic                                     busy_o,
  input  logic [cdm_pkg::CDM_FRAC_BITS-1:0]        u_i,
  input  logic [cdm_pkg::CDM_FRAC_BITS-1:0]        v_i,
  input  logic                                     done_o,
  input  logic signed [cdm_pkg::CDM_FRAC_BITS+1:0] disk_x_o,
  input  logic signed [cdm_pkg::CDM_FRAC_BITS+1:0] disk_y_o,
  output int                                       fail_count,
  output int                                       pending_count,
  output int                                       point_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import cdm_pkg::*;

  localparam int FB = CDM_FRAC_BITS;
  localparam longint ANG_FRAC = 30;
  localparam longint QUARTER_PI = 843314857;
  localparam longint CORDIC_GAIN = 652032874;
  localparam longint ARCTAN_LUT [10] = '{843314856, 497837829, 263043836, 133525158,
    67021686, 33543515, 16775850, 8388437, 4194282, 2097149};

  typedef struct {
    logic signed [FB+1:0] x;
    logic signed [FB+1:0] y;
  } disk_point_t;

  disk_point_t points_due[$];
  int mismatches;

  // Scale a trig value by the radius, round, clamp to the unit range.
  function automatic logic signed [FB+1:0] scale_round(input longint r, input longint trig);
    longint p;
    longint lim;
    lim = longint'(1) << FB;
    p = (r * trig + (longint'(1) << (ANG_FRAC - 1))) >>> ANG_FRAC;
    if (p > lim) p = lim;
    if (p < -lim) p = -lim;
    return p[FB+1:0];
  endfunction

  function automatic disk_point_t map_to_disk(input logic [FB-1:0] u, input logic [FB-1:0] v);
    disk_point_t pt;
    longint a, b, ma, mb, r, num, den, ratio, ang, cx, sy, z, dx, dy, step;
    bit first;
    a = 2 * longint'(u) - (longint'(1) << FB);
    b = 2 * longint'(v) - (longint'(1) << FB);
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    if (a == 0 && b == 0) begin
      pt.x = '0;
      pt.y = '0;
      return pt;
    end
    // The diagonal goes to the second branch.
    first = ma > mb;
    r   = first ? a : b;
    num = first ? b : a;
    den = first ? a : b;
    ratio = ((num < 0 ? -num : num) << ANG_FRAC) / (den < 0 ? -den : den);
    ang = (ratio * QUARTER_PI + (longint'(1) << (ANG_FRAC - 1))) >>> ANG_FRAC;
    if ((num < 0) != (den < 0)) ang = -ang;
    cx = CORDIC_GAIN;
    sy = 0;
    z  = ang;
    for (int i = 0; i < CDM_CORDIC_STEPS && i < 30; i++) begin
      step = (i < 10) ? ARCTAN_LUT[i] : (longint'(1) << (ANG_FRAC - i));
      dx = sy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx -= dx; sy += dy; z -= step;
      end else begin
        cx += dx; sy -= dy; z += step;
      end
    end
    // Second branch swaps sine and cosine.
    pt.x = scale_round(r, first ? cx : sy);
    pt.y = scale_round(r, first ? sy : cx);
    return pt;
  endfunction

  assign pending_count = points_due.size();

  always @(posedge clk_i or negedge rst_ni) begin
    disk_point_t want;
    if (!rst_ni) begin
      points_due.delete();
      fail_count  <= 0;
      mismatches  = 0;
      point_count <= 0;
    end else begin
      if (done_o) begin
        point_count <= point_count + 1;
        if (points_due.size() == 0) begin
          fail_count <= fail_count + 1;
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected point x=%0d y=%0d", disk_x_o, disk_y_o);
        end else begin
          want = points_due.pop_front();
          if (want.x !== disk_x_o || want.y !== disk_y_o) begin
            fail_count <= fail_count + 1;
            mismatches++;
            if (mismatches <= 10)
              $display("point mismatch: expected (%0d,%0d) got (%0d,%0d)",
                       want.x, want.y, disk_x_o, disk_y_o);
          end
        end
      end
      if (start_i && !busy_o) points_due.push_back(map_to_disk(u_i, v_i));
    end
  end
endmodule

/* dv/testbench.sv */
// Top of the concentric disk map testbench: clock, reset, sample stimulus
// and verdict. Depends on cdm_pkg, concentric_disk_map_top and cdm_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cdm_pkg::*;

  localparam int FB = CDM_FRAC_BITS;
  localparam int PIPE_DEPTH = 36 + CDM_CORDIC_STEPS;
  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [FB-1:0] u_i = '0;
  logic [FB-1:0] v_i = '0;
  logic busy_o, done_o;
  logic signed [FB+1:0] disk_x_o, disk_y_o;
  int fail_count, pending_count, point_count;
  int cycles = 0;
  int samples_sent = 0;
  int near_center = 0;
  int on_diagonal = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  concentric_disk_map_top dut (.*);

  cdm_checker checker_inst (.*);

  // Hard stop in case the pipeline never drains.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL concentric_disk_map_top");
      $finish;
    end
  end

  // Drive one sample and hold it until the transfer; busy_o read right after
  // the edge is the value that edge saw.
  task automatic send_sample(input logic [FB-1:0] u, input logic [FB-1:0] v, input bit idle_ok);
    while (idle_ok && $urandom_range(99) < 28) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    u_i <= u;
    v_i <= v;
    samples_sent++;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  initial begin
    logic [FB-1:0] u, v;
    int shape;
    int wait_cycles;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: center, corners, edge midpoints, both diagonals, near-center.
    send_sample(16'h8000, 16'h8000, 0);
    send_sample(16'h0000, 16'h0000, 0);
    send_sample(16'hFFFF, 16'hFFFF, 0);
    send_sample(16'h0000, 16'hFFFF, 0);
    send_sample(16'hFFFF, 16'h0000, 0);
    send_sample(16'h8000, 16'h0000, 0);
    send_sample(16'h8000, 16'hFFFF, 0);
    send_sample(16'h0000, 16'h8000, 0);
    send_sample(16'hFFFF, 16'h8000, 0);
    send_sample(16'hC000, 16'hC000, 1);
    send_sample(16'h4000, 16'hC000, 1);
    send_sample(16'hC000, 16'h4000, 1);
    send_sample(16'h4000, 16'h4000, 1);
    send_sample(16'h8001, 16'h8000, 1);
    send_sample(16'h8000, 16'h7FFF, 1);
    send_sample(16'h7FFF, 16'h8001, 1);
    send_sample(16'hA000, 16'h9FFF, 1);
    send_sample(16'h0001, 16'hFFFE, 1);
    send_sample(16'h5555, 16'hAAAA, 1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      shape = $urandom_range(9);
      u = $urandom();
      v = $urandom();
      case (shape)
        0: begin
          u = 16'h8000 + 16'($urandom_range(8)) - 16'd4;
          v = 16'h8000 + 16'($urandom_range(8)) - 16'd4;
          near_center++;
        end
        1: begin
          v = u;
          on_diagonal++;
        end
        2: begin
          v = 16'h0000 - u;
          on_diagonal++;
        end
        3: v = u + 16'($urandom_range(2)) - 16'd1;
        default: ;
      endcase
      // Leave a long burst with back-to-back transfers.
      send_sample(u, v, !(n >= 600 && n < 900));
    end
    start_i <= 1'b0;

    while (pending_count != 0) @(posedge clk_i);
    wait_cycles = 0;
    while (wait_cycles < PIPE_DEPTH + 16) begin
      @(posedge clk_i);
      wait_cycles++;
    end

    $display("sent %0d samples (%0d near center, %0d on diagonals), checked %0d points",
             samples_sent, near_center, on_diagonal, point_count);
    if (fail_count == 0)
      $display("PASS concentric_disk_map_top");
    else
      $display("FAIL concentric_disk_map_top");
    $finish;
  end
endmodule

/* sim.f */
rtl/cdm_pkg.sv
rtl/cdm_div.sv
rtl/cdm_cordic.sv
rtl/concentric_disk_map_top.sv
dv/cdm_checker.sv
dv/testbench.sv
